[hdl/lkvc_pkg.sv]
// types, constants and sizes shared by the key-value cache modules
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CNT_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;
  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(ENTRIES);

  typedef logic [DATA_W-1:0]              word_t;
  typedef logic [IDX_W-1:0]               rank_t;
  typedef logic [OCC_W-1:0]               occ_t;
  typedef logic [CAP_W-1:0]               cap_t;
  typedef logic [ENTRIES-1:0]             vec_t;
  typedef logic [ENTRIES-1:0][DATA_W-1:0] word_arr_t;
  typedef logic [ENTRIES-1:0][IDX_W-1:0]  rank_arr_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic  hit;
    vec_t  hit_onehot;
    word_t hit_value;
    rank_t hit_rank;
    logic  evict;
    vec_t  victim_onehot;
    vec_t  slot_onehot;
  } lookup_t;

endpackage
`default_nettype wire

[hdl/lru_key_value_cache_top.sv]
// top level of the fully associative key-value cache with true lru replacement
`timescale 1ns / 1ps
`default_nettype none
// Accepts one get or put beat per cycle while req_ready is high and returns
// exactly one response beat for each, in order. The request lands in an input
// register at the accepting edge. From there, when the response side does not
// stall, a single pass of tag compare, victim pick and rank update writes the
// entry registers and the response register together. The response is offered
// once written. Back-to-back beats always see the state the
// previous beat left. req_ready only drops while a response waits unaccepted
// and a request is already held. cfg_ready is always high; write the capacity
// only while no beat is in flight. A capacity of 0 acts as 1, above 16 acts
// as 16. Lowering it does not flush entries; each later put miss evicts one.
module lru_key_value_cache_top (
  input  wire  logic                   clk,
  input  wire  logic                   rst,
  input  wire  logic                   req_valid,
  output logic                         req_ready,
  input  wire  lkvc_pkg::req_t         req,
  output logic                         rsp_valid,
  input  wire  logic                   rsp_ready,
  output lkvc_pkg::rsp_t               rsp,
  input  wire  logic                   cfg_valid,
  output logic                         cfg_ready,
  input  wire  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);

  lkvc_pkg::req_t      ireg;
  logic                ireg_valid;
  logic                advance;
  lkvc_pkg::cap_t      capacity;
  lkvc_pkg::lookup_t   lk;
  lkvc_pkg::word_arr_t tags;
  lkvc_pkg::word_arr_t values;
  lkvc_pkg::rank_arr_t ranks;
  lkvc_pkg::vec_t      valid;
  lkvc_pkg::occ_t      occ;
  lkvc_pkg::rsp_t      rsp_next;

  assign advance   = ireg_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !ireg_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (req_ready) begin
      ireg_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      ireg <= req;
    end
  end

  lkvc_lookup u_lookup (
    .key      (ireg.lookup_key),
    .tags     (tags),
    .values   (values),
    .ranks    (ranks),
    .valid    (valid),
    .occ      (occ),
    .capacity (capacity),
    .lk       (lk)
  );

  lkvc_store u_store (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .req    (ireg),
    .lk     (lk),
    .tags   (tags),
    .values (values),
    .ranks  (ranks),
    .valid  (valid),
    .occ    (occ)
  );

  always_comb begin
    rsp_next.hit = lk.hit;
    if (ireg.action == lkvc_pkg::ACT_PUT) begin
      rsp_next.read_value = lkvc_pkg::PUT_VALUE;
    end else if (lk.hit) begin
      rsp_next.read_value = lk.hit_value;
    end else begin
      rsp_next.read_value = lkvc_pkg::MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= lkvc_pkg::OCC_W'(lkvc_pkg::ENTRIES))
    else $error("occupancy above entry count");

  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occ))
    else $error("valid bits disagree with occupancy");

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    ireg_valid |-> $onehot0(lk.hit_onehot))
    else $error("key present in more than one entry");

  a_slot_found: assert property (@(posedge clk) disable iff (rst)
    (advance && ireg.action == lkvc_pkg::ACT_PUT && !lk.hit) |-> $onehot(lk.slot_onehot))
    else $error("put miss without a free slot");

  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("response beat lost");

endmodule
`default_nettype wire

[hdl/lkvc_lookup.sv]
// parallel tag compare, victim choice and free slot search
`timescale 1ns / 1ps
`default_nettype none
module lkvc_lookup (
  input  wire  logic [31:0]        key,
  input  wire  lkvc_pkg::word_arr_t tags,
  input  wire  lkvc_pkg::word_arr_t values,
  input  wire  lkvc_pkg::rank_arr_t ranks,
  input  wire  lkvc_pkg::vec_t      valid,
  input  wire  lkvc_pkg::occ_t      occ,
  input  wire  lkvc_pkg::cap_t      capacity,
  output lkvc_pkg::lookup_t         lk
);

  logic [lkvc_pkg::CNT_W-1:0] occ_w;
  logic [lkvc_pkg::CNT_W-1:0] cap_w;
  lkvc_pkg::occ_t             occ_m1;
  lkvc_pkg::vec_t             free;
  lkvc_pkg::vec_t             match;
  lkvc_pkg::word_t            hval;
  lkvc_pkg::rank_t            hrank;
  lkvc_pkg::vec_t             victim;
  logic                       full;

  always_comb begin
    match = '0;
    hval  = '0;
    hrank = '0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      match[i] = valid[i] && (tags[i] == key);
      hval     = hval | (match[i] ? values[i] : '0);
      hrank    = hrank | (match[i] ? ranks[i] : '0);
    end
  end

  // least recent entry holds rank occupancy-1
  always_comb begin
    occ_w  = lkvc_pkg::CNT_W'(occ);
    cap_w  = lkvc_pkg::CNT_W'(capacity);
    occ_m1 = occ - lkvc_pkg::OCC_W'(1);
    full   = (occ != '0) &&
             ((occ_w >= cap_w) || (occ_w >= lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES)));
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      victim[i] = full && valid[i] && (ranks[i] == occ_m1[lkvc_pkg::IDX_W-1:0]);
    end
    free = ~(valid & ~victim);
  end

  always_comb begin
    lk.hit           = |match;
    lk.hit_onehot    = match;
    lk.hit_value     = hval;
    lk.hit_rank      = hrank;
    lk.evict         = full;
    lk.victim_onehot = victim;
    lk.slot_onehot   = free & (~free + lkvc_pkg::ENTRIES'(1));
  end

endmodule
`default_nettype wire

[hdl/lkvc_store.sv]
// entry registers: tags, values, recency ranks, valid bits and occupancy
`timescale 1ns / 1ps
`default_nettype none
module lkvc_store (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                step,
  input  wire  lkvc_pkg::req_t      req,
  input  wire  lkvc_pkg::lookup_t   lk,
  output lkvc_pkg::word_arr_t       tags,
  output lkvc_pkg::word_arr_t       values,
  output lkvc_pkg::rank_arr_t       ranks,
  output lkvc_pkg::vec_t            valid,
  output lkvc_pkg::occ_t            occ
);

  lkvc_pkg::word_arr_t tags_next;
  lkvc_pkg::word_arr_t values_next;
  lkvc_pkg::rank_arr_t ranks_next;
  lkvc_pkg::vec_t      valid_next;
  lkvc_pkg::occ_t      occ_next;

  always_comb begin
    tags_next   = tags;
    values_next = values;
    ranks_next  = ranks;
    valid_next  = valid;
    occ_next    = occ;
    if (step) begin
      if (lk.hit) begin
        // promote the hit entry, age the ones that were more recent
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (lk.hit_onehot[i]) begin
            ranks_next[i] = '0;
            if (req.action == lkvc_pkg::ACT_PUT) begin
              values_next[i] = req.write_value;
            end
          end else if (valid[i] && (ranks[i] < lk.hit_rank)) begin
            ranks_next[i] = ranks[i] + lkvc_pkg::IDX_W'(1);
          end
        end
      end else if (req.action == lkvc_pkg::ACT_PUT) begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (lk.slot_onehot[i]) begin
            tags_next[i]   = req.lookup_key;
            values_next[i] = req.write_value;
            ranks_next[i]  = '0;
            valid_next[i]  = 1'b1;
          end else if (lk.victim_onehot[i]) begin
            valid_next[i] = 1'b0;
          end else if (valid[i]) begin
            ranks_next[i] = ranks[i] + lkvc_pkg::IDX_W'(1);
          end
        end
        if (!lk.evict) begin
          occ_next = occ + lkvc_pkg::OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
    end else begin
      valid <= valid_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    tags   <= tags_next;
    values <= values_next;
    ranks  <= ranks_next;
  end

endmodule
`default_nettype wire

[verif/lkvc_access_checker.sv]
// checker for the key-value cache: predicts each access and compares responses in order
`timescale 1ns / 1ps
module lkvc_access_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_ready,
  input  lkvc_pkg::req_t                req,
  input  logic                          rsp_valid,
  input  logic                          rsp_ready,
  input  lkvc_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            open_count
);
  import lkvc_pkg::*;

  // shadow copy of the cache contents
  bit [DATA_W-1:0] key_tags[ENTRIES];
  bit [DATA_W-1:0] data_words[ENTRIES];
  bit              live[ENTRIES];
  bit [IDX_W-1:0]  ages[ENTRIES];
  int              fill;
  bit [CAP_W-1:0]  cap_setting;

  rsp_t expected_rsp[$];
  rsp_t want;
  int   fails = 0;

  assign mismatches = fails;

  function automatic int usable_slots();
    int c;
    c = cap_setting;
    if (c < 1) c = 1;
    if (c > ENTRIES) c = ENTRIES;
    return c;
  endfunction

  function automatic void make_newest(int idx);
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && i != idx && ages[i] < ages[idx])
        ages[i] = ages[i] + 1'b1;
    ages[idx] = '0;
  endfunction

  function automatic int drop_oldest();
    int victim;
    victim = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && (victim < 0 || ages[i] > ages[victim]))
        victim = i;
    if (victim >= 0) begin
      live[victim] = 1'b0;
      if (fill > 0) fill--;
    end
    return victim;
  endfunction

  function automatic rsp_t predict_access(req_t a);
    rsp_t r;
    int at;
    int slot;
    bit [DATA_W-1:0] k;
    k = a.lookup_key;
    at = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (at < 0 && live[i] && key_tags[i] == k) at = i;
    if (a.action == ACT_GET) begin
      if (at >= 0) begin
        r.hit = 1'b1;
        r.read_value = data_words[at];
        make_newest(at);
      end else begin
        r.hit = 1'b0;
        r.read_value = MISS_VALUE;
      end
      return r;
    end
    r.read_value = PUT_VALUE;
    if (at >= 0) begin
      r.hit = 1'b1;
      data_words[at] = a.write_value;
      make_newest(at);
      return r;
    end
    r.hit = 1'b0;
    slot = -1;
    if (fill >= usable_slots()) void'(drop_oldest());
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && !live[i]) slot = i;
    if (slot < 0) slot = drop_oldest();
    if (slot < 0) return r;
    for (int i = 0; i < ENTRIES; i++)
      if (live[i]) ages[i] = ages[i] + 1'b1;
    key_tags[slot] = k;
    data_words[slot] = a.write_value;
    ages[slot] = '0;
    live[slot] = 1'b1;
    fill++;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) live[i] = 1'b0;
      fill = 0;
      cap_setting = CAP_RESET;
      expected_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_setting = cfg_data;
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          fails++;
          $display("%0t unexpected response: expected none actual hit %0b value %h",
                   $time, rsp.hit, rsp.read_value);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.hit !== want.hit) begin
            fails++;
            $display("%0t hit mismatch: expected %0b actual %0b",
                     $time, want.hit, rsp.hit);
          end
          if (rsp.read_value !== want.read_value) begin
            fails++;
            $display("%0t read_value mismatch: expected %h actual %h",
                     $time, want.read_value, rsp.read_value);
          end
        end
      end
      if (req_valid && req_ready) expected_rsp.push_back(predict_access(req));
    end
    open_count <= expected_rsp.size();
  end

endmodule

[verif/lru_key_value_cache_top_test.sv]
// testbench top for the key-value cache: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
module lru_key_value_cache_top_test;
  import lkvc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 110;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  int mismatches;
  int open_count;
  int cycles = 0;
  int send_mode = 1;
  int recv_mode = 1;
  int rsp_beats = 0;
  logic [DATA_W-1:0] key_pool[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_key_value_cache_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lkvc_access_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .open_count (open_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // 0: no gaps, 1: gaps 0..14, 2: mostly back to back
  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 14);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic logic [DATA_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r < 93) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  task automatic send_access(input logic act, input logic [DATA_W-1:0] key,
                             input logic [DATA_W-1:0] value);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= {act, key, value};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int pool_n, input int mode);
    write_capacity(cap);
    send_mode = mode;
    recv_mode = (mode + 1) % 3;
    key_pool.delete();
    repeat (pool_n) key_pool.push_back($urandom);
    repeat (PHASE_ITEMS) send_access(1'($urandom_range(0, 1)), pick_key(), $urandom);
  endtask

  // response side: random hold-offs per beat, two long stalls to back up the input
  initial begin
    while (rst) @(posedge clk);
    forever begin
      int gap;
      gap = draw_gap(recv_mode);
      if (rsp_beats == 300 || rsp_beats == 800) gap = 80;
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      rsp_beats++;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // two entries: fill, promote, evict, update
    write_capacity(5'd2);
    send_access(ACT_GET, 32'h0000_0000, 32'h1234_5678);
    send_access(ACT_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_access(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_access(ACT_GET, 32'h8000_0000, 32'h0000_0000);
    send_access(ACT_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_access(ACT_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_access(ACT_PUT, 32'h8000_0000, 32'h0000_0000);
    send_access(ACT_GET, 32'h8000_0000, 32'haaaa_5555);
    send_access(ACT_GET, 32'hffff_ffff, 32'h0000_0000);
    send_access(ACT_PUT, 32'h0000_0000, 32'h5555_aaaa);
    send_access(ACT_GET, 32'h0000_0000, 32'hdead_beef);

    // grow, then shrink below the current fill
    write_capacity(5'd16);
    for (int i = 1; i <= 6; i++) send_access(ACT_PUT, i, ~i);
    write_capacity(5'd3);
    send_access(ACT_PUT, 32'd7, 32'd70);
    send_access(ACT_GET, 32'd0, 32'd0);
    send_access(ACT_PUT, 32'd8, 32'd80);
    send_access(ACT_GET, 32'd6, 32'd0);
    send_access(ACT_GET, 32'd1, 32'd0);

    // zero capacity behaves as one
    write_capacity(5'd0);
    send_access(ACT_PUT, 32'd9, 32'd90);
    send_access(ACT_GET, 32'd9, 32'd0);
    send_access(ACT_GET, 32'd8, 32'd0);

    run_phase(5'd16, 20, 0);
    run_phase(5'd1, 3, 1);
    run_phase(5'd0, 2, 2);
    run_phase(5'd31, 22, 1);
    run_phase(5'd4, 6, 2);
    run_phase(5'd8, 11, 0);
    run_phase(5'd2, 4, 1);
    run_phase(5'd17, 19, 2);
    run_phase(5'd12, 15, 1);
    run_phase(5'd16, 18, 2);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
